/* hdl/sbd_pkg.sv */
// shared types and constants of the soh block deframer
`timescale 1ns / 1ps

package sbd_pkg;

   // event codes on the request channel
   typedef enum logic [1:0] {
      OP_BYTE     = 2'd0,
      OP_TIMEOUT  = 2'd1,
      OP_READ_ERR = 2'd2
   } opcode_type;

   // kinds of response transaction
   typedef enum logic [1:0] {
      KIND_TYPE = 2'd0,
      KIND_DATA = 2'd1,
      KIND_END  = 2'd2
   } item_kind_type;

   // end-of-block status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_TIMEOUT = 3'd1,
      ST_READ    = 3'd2,
      ST_CHKSUM  = 3'd3,
      ST_SEQ     = 3'd4,
      ST_LENGTH  = 3'd5
   } status_type;

   // register indexes on the csr port
   localparam logic REG_START_CODE = 1'b0;
   localparam logic REG_BYTE_LIMIT = 1'b1;

   localparam int        CSR_ADDR_W       = 3;
   localparam logic [7:0] START_CODE_RESET = 8'd1;
   localparam logic [8:0] BYTE_LIMIT_RESET = 9'd270;
   localparam logic [8:0] BYTE_CNT_MAX     = 9'h1ff;

   // one response transaction
   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] payload_byte;
      logic [2:0] status_code;
      logic [7:0] payload_count;
   } result_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

/* hdl/sbd_intf.sv */
// request and response channel interfaces
`timescale 1ns / 1ps

interface sbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] item_kind;
   logic [7:0] payload_byte;
   logic [2:0] status_code;
   logic [7:0] payload_count;

   modport source (output valid, output item_kind, output payload_byte,
                   output status_code, output payload_count, input ready);
   modport sink   (input valid, input item_kind, input payload_byte,
                   input status_code, input payload_count, output ready);
endinterface

/* hdl/sbd_front.sv */
// front end: accepts events, tracks the block framing, produces results
`timescale 1ns / 1ps

module sbd_front
   import sbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   sbd_req_if.sink        req,
   input  logic [7:0]     start_code,
   input  logic [8:0]     byte_limit,
   input  queue_stat_type q_stat,
   output logic           push,
   output result_type     push_data
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_SEQ  = 3'd2,
      PH_TYPE = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] exp_seq_ff, exp_seq_in;
   logic [8:0] byte_cnt_ff, byte_cnt_in;
   logic [7:0] saved_len_ff, saved_len_in;

   logic       accept;
   logic       fin;
   logic       check_limit;
   status_type fin_status;
   logic [7:0] fin_count;
   logic [7:0] rem_dec;
   logic [8:0] cnt_inc;
   logic [7:0] b;

   assign req.ready = ~q_stat.full;
   assign accept    = req.valid & req.ready;
   assign b         = req.rx_byte;
   assign rem_dec   = (remaining_ff != 8'd0) ? remaining_ff - 8'd1 : remaining_ff;
   assign cnt_inc   = (byte_cnt_ff != BYTE_CNT_MAX) ? byte_cnt_ff + 9'd1 : byte_cnt_ff;

   // next state and result for the accepted transaction
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      exp_seq_in   = exp_seq_ff;
      byte_cnt_in  = byte_cnt_ff;
      saved_len_in = saved_len_ff;
      push         = 1'b0;
      push_data    = '0;
      fin          = 1'b0;
      check_limit  = 1'b0;
      fin_status   = ST_OK;
      fin_count    = 8'd0;

      if (accept) begin
         case (opcode_type'(req.opcode))
            OP_TIMEOUT: begin
               fin        = 1'b1;
               fin_status = ST_TIMEOUT;
            end
            OP_READ_ERR: begin
               fin        = 1'b1;
               fin_status = ST_READ;
            end
            OP_BYTE: begin
               case (phase_ff)
                  PH_HUNT: begin
                     if (b == start_code) begin
                        phase_in = PH_LEN;
                     end
                     byte_cnt_in = cnt_inc;
                     check_limit = 1'b1;
                  end
                  PH_LEN: begin
                     saved_len_in = b;
                     remaining_in = b;
                     sum_in       = b;
                     phase_in     = PH_SEQ;
                     byte_cnt_in  = 9'd1;
                     check_limit  = 1'b1;
                  end
                  PH_SEQ: begin
                     exp_seq_in = exp_seq_ff + 8'd1;
                     if (b != exp_seq_in) begin
                        fin        = 1'b1;
                        fin_status = ST_SEQ;
                     end else begin
                        sum_in       = sum_ff + b;
                        remaining_in = rem_dec;
                        phase_in     = PH_TYPE;
                        byte_cnt_in  = cnt_inc;
                        check_limit  = 1'b1;
                     end
                  end
                  PH_TYPE: begin
                     sum_in                 = sum_ff + b;
                     remaining_in           = rem_dec;
                     phase_in               = PH_DATA;
                     byte_cnt_in            = cnt_inc;
                     check_limit            = 1'b1;
                     push                   = 1'b1;
                     push_data.item_kind    = KIND_TYPE;
                     push_data.payload_byte = b;
                  end
                  PH_DATA: begin
                     if (remaining_ff > 8'd1) begin
                        sum_in                 = sum_ff + b;
                        remaining_in           = rem_dec;
                        byte_cnt_in            = cnt_inc;
                        check_limit            = 1'b1;
                        push                   = 1'b1;
                        push_data.item_kind    = KIND_DATA;
                        push_data.payload_byte = b;
                     end else begin
                        // checksum byte closes the block
                        fin = 1'b1;
                        if (sum_ff != b) begin
                           fin_status = ST_CHKSUM;
                        end else if (saved_len_ff < 8'd2) begin
                           fin_status = ST_LENGTH;
                        end else begin
                           fin_status = ST_OK;
                           fin_count  = saved_len_ff - 8'd2;
                        end
                     end
                  end
                  default: begin
                     phase_in    = PH_HUNT;
                     byte_cnt_in = cnt_inc;
                     check_limit = 1'b1;
                  end
               endcase
            end
            default: begin
               // unknown event is dropped
            end
         endcase

         // byte limit reached replaces any type or data result
         if (check_limit && (byte_cnt_in >= byte_limit)) begin
            fin        = 1'b1;
            fin_status = ST_LENGTH;
         end

         // end of block: emit status and go back to hunting
         if (fin) begin
            phase_in                = PH_HUNT;
            remaining_in            = 8'd0;
            sum_in                  = 8'd0;
            byte_cnt_in             = 9'd0;
            saved_len_in            = 8'd0;
            push                    = 1'b1;
            push_data.item_kind     = KIND_END;
            push_data.payload_byte  = 8'd0;
            push_data.status_code   = fin_status;
            push_data.payload_count = fin_count;
         end
      end
   end

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         remaining_ff <= 8'd0;
         sum_ff       <= 8'd0;
         exp_seq_ff   <= 8'd0;
         byte_cnt_ff  <= 9'd0;
         saved_len_ff <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         exp_seq_ff   <= exp_seq_in;
         byte_cnt_ff  <= byte_cnt_in;
         saved_len_ff <= saved_len_in;
      end
   end

endmodule

/* hdl/sbd_queue.sv */
// short result queue between front and back
`timescale 1ns / 1ps

module sbd_queue
   import sbd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  result_type     push_data,
   input  logic           pop,
   output result_type     head_data,
   output queue_stat_type q_stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   result_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_stat.full  = (count_ff == CNT_FULL);
   assign q_stat.empty = (count_ff == '0);
   assign head_data    = mem_ff[rd_ptr_ff];
   assign do_push      = push & ~q_stat.full;
   assign do_pop       = pop & ~q_stat.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/sbd_back.sv */
// back end: drains the queue into the response output register
`timescale 1ns / 1ps

module sbd_back
   import sbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_stat_type q_stat,
   input  result_type     head_data,
   output logic           pop,
   sbd_rsp_if.source      rsp
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       load;

   // output register takes a new transaction when empty or being taken
   assign load         = ~rsp_valid_ff | rsp.ready;
   assign pop          = load & ~q_stat.empty;
   assign rsp_valid_in = load ? ~q_stat.empty : rsp_valid_ff;
   assign rsp_data_in  = pop ? head_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.item_kind     = rsp_data_ff.item_kind;
   assign rsp.payload_byte  = rsp_data_ff.payload_byte;
   assign rsp.status_code   = rsp_data_ff.status_code;
   assign rsp.payload_count = rsp_data_ff.payload_count;

endmodule

/* hdl/soh_block_deframer_top.sv */
// top level of the soh block deframer with its csr registers
// path: a result is written into the result queue and then loaded into the rsp output register
// throughput: one request transaction per cycle while the result queue is not full, set by the
//   framing update in the front end; the result queue absorbs rsp stalls until it is full
// reset: synchronous, active high; back to hunting, expected sequence 0,
//   start_code 1 and byte_limit 270, queue and output register empty
`timescale 1ns / 1ps

module soh_block_deframer_top
   import sbd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   sbd_req_if.sink               req_chan,
   sbd_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]     start_code_ff, start_code_in;
   logic [8:0]     byte_limit_ff, byte_limit_in;
   logic           csr_write;
   logic           reg_sel;
   logic           push;
   logic           pop;
   result_type     push_data;
   result_type     head_data;
   queue_stat_type q_stat;

   // csr write decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      start_code_in = start_code_ff;
      byte_limit_in = byte_limit_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_START_CODE: start_code_in = csr_pwdata[7:0];
            REG_BYTE_LIMIT: byte_limit_in = csr_pwdata[8:0];
            default: begin
               start_code_in = start_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         byte_limit_ff <= BYTE_LIMIT_RESET;
      end else begin
         start_code_ff <= start_code_in;
         byte_limit_ff <= byte_limit_in;
      end
   end

   // csr read mux
   always_comb begin
      case (reg_sel)
         REG_START_CODE: csr_prdata = {24'd0, start_code_ff};
         REG_BYTE_LIMIT: csr_prdata = {23'd0, byte_limit_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   sbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .start_code (start_code_ff),
      .byte_limit (byte_limit_ff),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   sbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_stat    (q_stat)
   );

   sbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_data (head_data),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule
